>>> rtl/mje_pkg.sv
// ----------------------------------------------------------------------------
// mje_pkg
// Shared types, constants and saturation helpers for the escape-time engine.
// ----------------------------------------------------------------------------
package mje_pkg;

  // Q12.36 datapath
  localparam int DP_W    = 48;
  localparam int DP_FRAC = 36;
  localparam logic signed [DP_W-1:0] DP_MAX = {1'b0, {(DP_W-1){1'b1}}};
  localparam logic signed [DP_W-1:0] DP_MIN = {1'b1, {(DP_W-1){1'b0}}};
  localparam logic signed [DP_W-1:0] ESC_LIM = 48'sd4 <<< DP_FRAC;

  // Field widths
  localparam int CNT_W  = 16;
  localparam int EXPR_W = 4;   // exponent register
  localparam int P_W    = 5;   // clamped power, covers every allowed MAX_EXPONENT
  localparam int IDX_W  = 3;

  // Defaults
  localparam int DEF_COORD_WIDTH  = 32;
  localparam int DEF_MAX_EXPONENT = 8;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_KIND       = 3'd0,
    REG_ITER_LIMIT = 3'd1,
    REG_EXPONENT   = 3'd2,
    REG_C_RE       = 3'd3,
    REG_C_IM       = 3'd4
  } reg_idx_t;

  // Work item handed from the front to the engine
  typedef struct packed {
    logic signed [DP_W-1:0] zr;
    logic signed [DP_W-1:0] zi;
    logic signed [DP_W-1:0] cr;
    logic signed [DP_W-1:0] ci;
    logic [P_W-1:0]         p;
    logic [CNT_W-1:0]       iter_limit;
  } item_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_CHK,
    E_ESC,
    E_ESCCMP,
    E_PWR,
    E_CMUL,
    E_CCOMB,
    E_ADDC,
    E_EMIT
  } eng_state_t;

  // Saturate a grown sum back to Q12.36
  function automatic logic signed [DP_W-1:0] sat_dp(input logic signed [DP_W:0] v);
    logic signed [DP_W-1:0] r;
    if (v[DP_W] != v[DP_W-1]) begin
      r = v[DP_W] ? DP_MIN : DP_MAX;
    end else begin
      r = v[DP_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DP_W-1:0] add_sat(input logic signed [DP_W-1:0] a,
                                                    input logic signed [DP_W-1:0] b);
    logic signed [DP_W:0] s;
    s = (DP_W+1)'(a) + (DP_W+1)'(b);
    return sat_dp(s);
  endfunction

  function automatic logic signed [DP_W-1:0] sub_sat(input logic signed [DP_W-1:0] a,
                                                    input logic signed [DP_W-1:0] b);
    logic signed [DP_W:0] s;
    s = (DP_W+1)'(a) - (DP_W+1)'(b);
    return sat_dp(s);
  endfunction

endpackage

>>> rtl/mje_queue.sv
// ----------------------------------------------------------------------------
// mje_queue
// Small first-in first-out queue of registers.
// ----------------------------------------------------------------------------
module mje_queue #(
  parameter int W     = 16,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // store entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

>>> rtl/mje_front.sv
// ----------------------------------------------------------------------------
// mje_front
// Holds the configuration registers and turns each request into a work
// item: coordinates moved to Q12.36, start value and constant chosen, power
// clamped.
// ----------------------------------------------------------------------------
module mje_front #(
  parameter int COORD_WIDTH  = mje_pkg::DEF_COORD_WIDTH,
  parameter int MAX_EXPONENT = mje_pkg::DEF_MAX_EXPONENT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mje_pkg::IDX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic signed [COORD_WIDTH-1:0] point_re,
  input  logic signed [COORD_WIDTH-1:0] point_im,
  output mje_pkg::item_t                item
);
  import mje_pkg::*;

  logic                   kind;
  logic [CNT_W-1:0]       iter_limit;
  logic [EXPR_W-1:0]      exponent;
  logic [COORD_WIDTH-1:0] c_re;
  logic [COORD_WIDTH-1:0] c_im;
  logic signed [DP_W-1:0] pr, pi, jr, ji;
  logic [P_W-1:0]         p;

  function automatic logic signed [DP_W-1:0] to_dp(input logic [COORD_WIDTH-1:0] x);
    logic [COORD_WIDTH-1:0] mag;
    logic [DP_W-1:0]        m;
    logic signed [DP_W-1:0] r;
    mag = '0;
    m   = '0;
    if (COORD_WIDTH <= 40) begin
      r = DP_W'($signed(x)) <<< (40 - COORD_WIDTH);
    end else begin
      mag = x[COORD_WIDTH-1] ? (~x + 1'b1) : x;
      m   = DP_W'(mag >> (COORD_WIDTH - 40));
      r   = x[COORD_WIDTH-1] ? -$signed(m) : $signed(m);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  // write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      kind       <= 1'b0;
      iter_limit <= CNT_W'(100);
      exponent   <= EXPR_W'(2);
      c_re       <= '0;
      c_im       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KIND:       kind       <= cfg_data[0];
        REG_ITER_LIMIT: iter_limit <= cfg_data[CNT_W-1:0];
        REG_EXPONENT:   exponent   <= cfg_data[EXPR_W-1:0];
        REG_C_RE:       c_re       <= cfg_data;
        REG_C_IM:       c_im       <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify the point
  always_comb begin
    pr = to_dp(point_re);
    pi = to_dp(point_im);
    jr = to_dp(c_re);
    ji = to_dp(c_im);
    if (exponent == '0) begin
      p = P_W'(1);
    end else if (P_W'(exponent) > P_W'(MAX_EXPONENT)) begin
      p = P_W'(MAX_EXPONENT);
    end else begin
      p = P_W'(exponent);
    end
    item.p          = p;
    item.iter_limit = iter_limit;
    if (kind) begin
      item.zr = pr;
      item.zi = pi;
      item.cr = jr;
      item.ci = ji;
    end else begin
      item.zr = '0;
      item.zi = '0;
      item.cr = pr;
      item.ci = pi;
    end
  end

endmodule

>>> rtl/mje_mul.sv
// ----------------------------------------------------------------------------
// mje_mul
// Q12.36 multiplier: four 24x24 partial products accumulated over cycles,
// magnitude truncated by 36 bits, then saturated.
// ----------------------------------------------------------------------------
module mje_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [mje_pkg::DP_W-1:0] a,
  input  logic signed [mje_pkg::DP_W-1:0] b,
  output logic                            done,
  output logic signed [mje_pkg::DP_W-1:0] res
);
  import mje_pkg::*;

  localparam int H     = DP_W / 2;
  localparam int ACC_W = 2 * DP_W;
  localparam int Q_W   = ACC_W - DP_FRAC;

  logic [DP_W-1:0]  ua, ub;
  logic             neg;
  logic [2:0]       cnt;
  logic             busy;
  logic [DP_W-1:0]  pp;
  logic [1:0]       ppsel;
  logic             ppv;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] pp_sh;
  logic [H-1:0]     opa, opb;
  logic [Q_W-1:0]   q;

  // pick the halves for this partial product
  always_comb begin
    opa = cnt[0] ? ua[DP_W-1:H] : ua[H-1:0];
    opb = cnt[1] ? ub[DP_W-1:H] : ub[H-1:0];
    case (ppsel)
      2'd0:    pp_sh = ACC_W'(pp);
      2'd3:    pp_sh = ACC_W'(pp) << (2 * H);
      default: pp_sh = ACC_W'(pp) << H;
    endcase
    q = acc[ACC_W-1:DP_FRAC];
  end

  // sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      ppv  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        ppv  <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        ppv <= (cnt < 3'd4);
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands, partial products, accumulation and result
  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= a[DP_W-1] ? DP_W'(-a) : DP_W'(a);
      ub  <= b[DP_W-1] ? DP_W'(-b) : DP_W'(b);
      neg <= a[DP_W-1] != b[DP_W-1];
      acc <= '0;
    end else if (busy) begin
      if (cnt < 3'd4) begin
        pp    <= DP_W'(opa * opb);
        ppsel <= cnt[1:0];
      end
      if (ppv) begin
        acc <= acc + pp_sh;
      end
      if (cnt == 3'd5) begin
        if (q[Q_W-1:DP_W-1] != '0) begin
          res <= neg ? DP_MIN : DP_MAX;
        end else begin
          res <= neg ? -$signed(DP_W'(q)) : $signed(DP_W'(q));
        end
      end
    end
  end

endmodule

>>> rtl/mje_engine.sv
// ----------------------------------------------------------------------------
// mje_engine
// Back end: runs the escape-time loop for one item on a shared multiplier and
// queues the iteration count as result (zero if the iteration limit is hit).
// ----------------------------------------------------------------------------
module mje_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_empty,
  input  mje_pkg::item_t               in_item,
  output logic                         in_pop,
  input  logic                         out_full,
  output logic                         out_push,
  output logic [mje_pkg::CNT_W-1:0]    out_count
);
  import mje_pkg::*;

  eng_state_t             state, state_next;
  logic signed [DP_W-1:0] zr, zi, cr, ci, rr, ri;
  logic signed [DP_W-1:0] t [4];
  logic [P_W-1:0]         p, k;
  logic [CNT_W-1:0]       count, iter_limit;
  logic [1:0]             j;
  logic [1:0]             sel;
  logic                   mul_start, mul_done;
  logic signed [DP_W-1:0] mul_a, mul_b, mul_res;
  logic signed [DP_W-1:0] mag2;

  mje_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign mag2      = add_sat(t[0], t[1]);
  assign out_count = count;

  // next state, multiplier issue and handshakes
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    sel        = 2'd0;
    in_pop     = 1'b0;
    out_push   = 1'b0;
    case (state)
      E_IDLE: begin
        if (!in_empty) begin
          in_pop     = 1'b1;
          state_next = E_CHK;
        end
      end
      E_CHK: begin
        if (count >= iter_limit) begin
          state_next = E_EMIT;
        end else begin
          mul_start  = 1'b1;
          state_next = E_ESC;
        end
      end
      E_ESC: begin
        if (mul_done) begin
          if (j == 2'd0) begin
            mul_start = 1'b1;
            sel       = 2'd1;
          end else begin
            state_next = E_ESCCMP;
          end
        end
      end
      E_ESCCMP: state_next = (mag2 > ESC_LIM) ? E_EMIT : E_PWR;
      E_PWR: begin
        if (k < p) begin
          mul_start  = 1'b1;
          state_next = E_CMUL;
        end else begin
          state_next = E_ADDC;
        end
      end
      E_CMUL: begin
        if (mul_done) begin
          if (j != 2'd3) begin
            mul_start = 1'b1;
            sel       = j + 1'b1;
          end else begin
            state_next = E_CCOMB;
          end
        end
      end
      E_CCOMB: state_next = E_PWR;
      E_ADDC:  state_next = E_CHK;
      E_EMIT: begin
        if (!out_full) begin
          out_push   = 1'b1;
          state_next = E_IDLE;
        end
      end
      default: state_next = E_IDLE;
    endcase

    // operand select: escape test squares, else complex product terms
    if (state == E_CHK || state == E_ESC) begin
      mul_a = sel[0] ? zi : zr;
      mul_b = sel[0] ? zi : zr;
    end else begin
      case (sel)
        2'd0:    begin mul_a = rr; mul_b = zr; end
        2'd1:    begin mul_a = ri; mul_b = zi; end
        2'd2:    begin mul_a = rr; mul_b = zi; end
        default: begin mul_a = ri; mul_b = zr; end
      endcase
    end
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        zr         <= in_item.zr;
        zi         <= in_item.zi;
        cr         <= in_item.cr;
        ci         <= in_item.ci;
        p          <= in_item.p;
        iter_limit <= in_item.iter_limit;
        count      <= '0;
      end
      E_CHK: begin
        j <= 2'd0;
        if (count >= iter_limit) begin
          count <= '0;
        end
      end
      E_ESC, E_CMUL: begin
        if (mul_done) begin
          t[j] <= mul_res;
          j    <= j + 1'b1;
        end
      end
      E_ESCCMP: begin
        rr <= zr;
        ri <= zi;
        k  <= P_W'(1);
      end
      E_PWR: j <= 2'd0;
      E_CCOMB: begin
        rr <= sub_sat(t[0], t[1]);
        ri <= add_sat(t[2], t[3]);
        k  <= k + 1'b1;
      end
      E_ADDC: begin
        zr    <= add_sat(rr, cr);
        zi    <= add_sat(ri, ci);
        count <= count + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/multibrot_julia_escape_time.sv
// ----------------------------------------------------------------------------
// multibrot_julia_escape_time
// Escape-time iterator for Multibrot and Julia sets, z = z^p + c.
// ----------------------------------------------------------------------------
// Each point pushed in is classified by the front (start value, constant and
// power taken from the configuration) and queued for the engine, which runs
// the loop on one shared Q12.36 multiplier. One iteration is two squares
// and a compare for the escape test, p - 1 complex multiplies of four
// products each, then the constant add. A point is iterated until it
// escapes or reaches the iteration limit, then its count is handed on; the
// engine finishes one point before it takes the next. The work queue holds
// up to two points ahead of the engine and two results wait in the output
// queue. Configuration writes are taken at once and apply to points pushed
// afterwards.
module multibrot_julia_escape_time #(
  parameter int COORD_WIDTH  = mje_pkg::DEF_COORD_WIDTH,
  parameter int MAX_EXPONENT = mje_pkg::DEF_MAX_EXPONENT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] point_re,
  input  logic signed [COORD_WIDTH-1:0] point_im,
  output logic                          empty,
  input  logic                          pop,
  output logic [mje_pkg::CNT_W-1:0]     iteration_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mje_pkg::IDX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);
  import mje_pkg::*;

  item_t            f_item, q_item;
  logic             q_empty, q_pop;
  logic             r_full, r_push;
  logic [CNT_W-1:0] r_count;

  mje_front #(
    .COORD_WIDTH  (COORD_WIDTH),
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point_re  (point_re),
    .point_im  (point_im),
    .item      (f_item)
  );

  mje_queue #(.W($bits(item_t)), .DEPTH(2)) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (f_item),
    .full  (full),
    .rd    (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  mje_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_empty  (q_empty),
    .in_item   (q_item),
    .in_pop    (q_pop),
    .out_full  (r_full),
    .out_push  (r_push),
    .out_count (r_count)
  );

  mje_queue #(.W(CNT_W), .DEPTH(2)) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (r_push),
    .wdata (r_count),
    .full  (r_full),
    .rd    (pop),
    .rdata (iteration_count),
    .empty (empty)
  );

endmodule

>>> rtl/mje_checker.sv
// ----------------------------------------------------------------------------
// mje_checker
// Port-level checks on the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module mje_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      push,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [mje_pkg::CNT_W-1:0] iteration_count
);
  logic [3:0] outstanding;

  // track requests taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 4'((push && !full) ? 1 : 0)
                                 - 4'((pop && !empty) ? 1 : 0);
    end
  end

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !empty |-> outstanding != 4'd0)
    else $error("result shown with no request outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 4'd5)
    else $error("more requests held than storage allows");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(iteration_count))
    else $error("waiting result changed or vanished");

endmodule

bind multibrot_julia_escape_time mje_checker u_mje_checker (
  .clk             (clk),
  .rst             (rst),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .iteration_count (iteration_count)
);
